/* rtl/probe_reference_match_assert.svh */
// Assertion macros for the probe reference matcher.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PROBE_REFERENCE_MATCH_ASSERT_SVH
`define PROBE_REFERENCE_MATCH_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PRM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PRM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/prm_pkg.sv */
// Shared types and constants for the probe reference matcher.
// No dependencies; imported by the controller, datapath and top level.
package prm_pkg;

    localparam int DIST_W = 16;
    localparam int IDX_W = 7;
    localparam logic [IDX_W-1:0] IDX_SAT = 7'd127;
    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 16'd4096;

    // Request action codes
    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } prm_action_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } prm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // latch request, reset scan pointers
        logic clear;    // empty the reference set
        logic load;     // handle a load element
        logic issue;    // read one reference entry for the scan
        logic advance;  // step the element index
        logic emit;     // write the result and end the vector
    } prm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic idx_in_range;
        logic idx_at_end;
        logic refs_present;
        logic scan_last;
        logic out_free;
        logic query_last;
    } prm_status_t;

endpackage

/* rtl/probe_reference_match.sv */
// One request in flight. Clear, load and unused requests complete in the idle state; a
// query element scans the R stored references, one reference per cycle through the store
// read port, then a compare stage and a finish cycle; with nothing scanned it goes straight
// to the finish cycle. A last element holds in the finish cycle while the previous result
// is stalled; its result is valid in the next cycle. Reset clears counters, running maxima
// and the result valid flag and sets the threshold to 16.0; the reference store has no reset.
`include "probe_reference_match_assert.svh"

module probe_reference_match #(
    parameter int SAMPLES  = 27,
    parameter int MAX_REFS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 action,
    input  logic [prm_pkg::DIST_W-1:0] distance,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       matched,
    output logic                       length_error,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [prm_pkg::DIST_W-1:0] cfg_data
);
    import prm_pkg::*;

    prm_cmd_t    cmd;
    prm_status_t st;

    // Threshold writes are always taken
    assign cfg_ready = 1'b1;

    prm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .last     (last),
        .st       (st),
        .cmd      (cmd)
    );

    prm_dpath #(
        .SAMPLES  (SAMPLES),
        .MAX_REFS (MAX_REFS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .distance     (distance),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .matched      (matched),
        .length_error (length_error),
        .cmd          (cmd),
        .st           (st)
    );

    // Checks
    `PRM_ASSERT_IMP(a_emit_when_free, cmd.emit, !(out_valid && out_stall), "result overwritten")
    `PRM_ASSERT_NXT(a_emit_shows, cmd.emit, out_valid, "emitted result not presented")
    `PRM_ASSERT_IMP(a_scan_has_refs, cmd.issue, st.refs_present, "scan with no references")

endmodule

/* rtl/prm_ctrl.sv */
// Sequencer for the probe reference matcher.
// Depends on prm_pkg for state, action, command and status types.
module prm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic                last,
    input  prm_pkg::prm_status_t st,
    output prm_pkg::prm_cmd_t    cmd
);
    import prm_pkg::*;

    prm_state_t state_reg;
    prm_state_t state_next;
    logic       take;
    logic       scan_go;

    assign take = in_valid && (state_reg == S_IDLE);
    // query element needs a scan when it is stored-range, refs exist, and
    // it is either a middle element or a correctly placed last one
    assign scan_go = st.idx_in_range && st.refs_present && (!last || st.idx_at_end);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && (prm_action_t'(action) == ACT_QUERY))
                begin
                    state_next = scan_go ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!st.query_last || st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.accept = 1'b1;
                    unique case (prm_action_t'(action))
                        ACT_CLEAR: cmd.clear = 1'b1;
                        ACT_LOAD:  cmd.load  = 1'b1;
                        ACT_QUERY: cmd.accept = 1'b1;
                        ACT_NONE:  cmd.accept = 1'b1;
                        default:   cmd.accept = 1'b1;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            S_DRAIN:
            begin
                cmd = '0;
            end
            S_DONE:
            begin
                if (!st.query_last)
                begin
                    cmd.advance = 1'b1;
                end
                else if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/prm_dpath.sv */
// Datapath of the probe reference matcher: reference store, running maxima,
// counters, threshold register and result register. Depends on prm_pkg.
module prm_dpath #(
    parameter int SAMPLES  = 27,
    parameter int MAX_REFS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [prm_pkg::DIST_W-1:0]   distance,
    input  logic                         last,
    input  logic                         cfg_valid,
    input  logic [prm_pkg::DIST_W-1:0]   cfg_data,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic                         matched,
    output logic                         length_error,
    input  prm_pkg::prm_cmd_t            cmd,
    output prm_pkg::prm_status_t         st
);
    import prm_pkg::*;

    localparam int DEPTH  = MAX_REFS * SAMPLES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BASE_W = $clog2(DEPTH + 1);
    localparam int REF_W  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int CNT_W  = $clog2(MAX_REFS + 1);
    localparam int SUM_W  = ((BASE_W > IDX_W) ? BASE_W : IDX_W) + 1;
    localparam logic [IDX_W-1:0]  SAMPLES_IDX  = IDX_W'(SAMPLES);
    localparam logic [IDX_W-1:0]  END_IDX      = IDX_W'(SAMPLES - 1);
    localparam logic [BASE_W-1:0] SAMPLES_BASE = BASE_W'(SAMPLES);
    localparam logic [CNT_W-1:0]  MAX_CNT      = CNT_W'(MAX_REFS);

    // Memories
    logic [DIST_W-1:0] store_mem [DEPTH];
    logic [DIST_W-1:0] rmax_mem  [MAX_REFS];

    // Registers
    logic [DIST_W-1:0]   thr_reg;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [BASE_W-1:0]   load_base_reg, load_base_next;
    logic [IDX_W-1:0]    idx_reg,       idx_next;
    logic [MAX_REFS-1:0] rmax_vld_reg,  rmax_vld_next;
    logic [DIST_W-1:0]   dist_reg;
    logic                last_reg;
    logic [REF_W-1:0]    scan_ref_reg;
    logic [BASE_W-1:0]   scan_base_reg;
    logic                pipe_vld_reg;
    logic [REF_W-1:0]    pipe_ref_reg;
    logic [DIST_W-1:0]   store_q_reg;
    logic [DIST_W-1:0]   rmax_q_reg;
    logic                hit_reg;
    logic                out_valid_reg;
    logic                matched_reg;
    logic                len_err_reg;

    logic                room;
    logic                idx_adv_sat;
    logic [IDX_W-1:0]    idx_inc;
    logic                store_we;
    logic [SUM_W-1:0]    wr_sum;
    logic [SUM_W-1:0]    rd_sum;
    logic [DIST_W-1:0]   delta;
    logic [DIST_W-1:0]   cur_max;
    logic [DIST_W-1:0]   new_max;

    // Status
    assign room            = (count_reg < MAX_CNT);
    assign st.idx_in_range = (idx_reg < SAMPLES_IDX);
    assign st.idx_at_end   = (idx_reg == END_IDX);
    assign st.refs_present = (count_reg != '0);
    assign st.scan_last    = ((CNT_W'(scan_ref_reg) + CNT_W'(1)) == count_reg);
    assign st.out_free     = !out_valid_reg || !out_stall;
    assign st.query_last   = last_reg;

    // Saturating element index step
    assign idx_adv_sat = (idx_reg == IDX_SAT);
    assign idx_inc     = idx_adv_sat ? idx_reg : (idx_reg + IDX_W'(1));

    // Store addresses: base of the reference plus element position
    assign wr_sum   = SUM_W'(load_base_reg) + SUM_W'(idx_reg);
    assign rd_sum   = SUM_W'(scan_base_reg) + SUM_W'(idx_reg);
    assign store_we = cmd.load && room && st.idx_in_range;

    // Reference set bookkeeping and vector position
    always_comb
    begin
        count_next     = count_reg;
        load_base_next = load_base_reg;
        idx_next       = idx_reg;
        rmax_vld_next  = rmax_vld_reg;
        if (pipe_vld_reg)
        begin
            rmax_vld_next[pipe_ref_reg] = 1'b1;
        end
        if (cmd.clear)
        begin
            count_next     = '0;
            load_base_next = '0;
            idx_next       = '0;
            rmax_vld_next  = '0;
        end
        else if (cmd.load)
        begin
            if (last)
            begin
                // commit only a complete reference with room left
                if (st.idx_at_end && room)
                begin
                    count_next     = count_reg + CNT_W'(1);
                    load_base_next = load_base_reg + SAMPLES_BASE;
                end
                idx_next      = '0;
                rmax_vld_next = '0;
            end
            else
            begin
                idx_next = idx_inc;
            end
        end
        else if (cmd.advance)
        begin
            idx_next = idx_inc;
        end
        else if (cmd.emit)
        begin
            idx_next      = '0;
            rmax_vld_next = '0;
        end
    end

    // Distance of the returning entry and its updated maximum
    always_comb
    begin
        delta   = (store_q_reg > dist_reg) ? (store_q_reg - dist_reg)
                                           : (dist_reg - store_q_reg);
        cur_max = rmax_vld_reg[pipe_ref_reg] ? rmax_q_reg : '0;
        new_max = (delta > cur_max) ? delta : cur_max;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESHOLD_RESET;
            count_reg     <= '0;
            load_base_reg <= '0;
            idx_reg       <= '0;
            rmax_vld_reg  <= '0;
            last_reg      <= 1'b0;
            scan_ref_reg  <= '0;
            scan_base_reg <= '0;
            pipe_vld_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            count_reg     <= count_next;
            load_base_reg <= load_base_next;
            idx_reg       <= idx_next;
            rmax_vld_reg  <= rmax_vld_next;
            pipe_vld_reg  <= cmd.issue;
            if (cmd.accept)
            begin
                last_reg      <= last;
                scan_ref_reg  <= '0;
                scan_base_reg <= '0;
                hit_reg       <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    scan_ref_reg  <= scan_ref_reg + REF_W'(1);
                    scan_base_reg <= scan_base_reg + SAMPLES_BASE;
                end
                if (pipe_vld_reg && (new_max < thr_reg))
                begin
                    hit_reg <= 1'b1;
                end
            end
            // result register: hold while stalled
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dist_reg <= distance;
        end
        if (cmd.issue)
        begin
            pipe_ref_reg <= scan_ref_reg;
        end
        if (cmd.emit)
        begin
            matched_reg <= hit_reg && st.idx_at_end;
            len_err_reg <= !st.idx_at_end;
        end
    end

    // Reference store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[wr_sum[ADDR_W-1:0]] <= distance;
        end
        if (cmd.issue)
        begin
            store_q_reg <= store_mem[rd_sum[ADDR_W-1:0]];
        end
    end

    // Running maxima: write back from the compare stage, read for the next entry
    always_ff @(posedge clk)
    begin
        if (pipe_vld_reg)
        begin
            rmax_mem[pipe_ref_reg] <= new_max;
        end
        if (cmd.issue)
        begin
            rmax_q_reg <= rmax_mem[scan_ref_reg];
        end
    end

    assign out_valid    = out_valid_reg;
    assign matched      = matched_reg;
    assign length_error = len_err_reg;

endmodule
